// ===== design/cmgi_pkg.sv =====
// package for the colormap gradient interpolator
// holds the breakpoint types, command and status codes, presets and fsm states
// no dependencies
package cmgi_pkg;

    // table size default
    localparam int MAX_POINTS_DEF = 16;

    // quotient bits of the fraction divider (fract runs up to 65536)
    localparam int DIV_STEPS = 17;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // command codes on kind
    localparam logic [2:0] K_INSERT = 3'd0;
    localparam logic [2:0] K_CLEAR  = 3'd1;
    localparam logic [2:0] K_JET    = 3'd2;
    localparam logic [2:0] K_HOT    = 3'd3;
    localparam logic [2:0] K_LOOKUP = 3'd4;

    // status codes
    localparam logic [1:0] STS_DONE  = 2'd0;
    localparam logic [1:0] STS_COLOR = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;
    localparam logic [1:0] STS_FULL  = 2'd3;

    // preset lengths
    localparam int JET_N = 8;
    localparam int HOT_N = 4;

    // one breakpoint
    typedef struct packed {
        logic [15:0] lvl;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } entry_t;

    // neighbor pair picked by a lookup
    typedef struct packed {
        entry_t prv;
        entry_t cur;
    } pair_t;

    // table update applied to all cells
    typedef enum logic [1:0] {
        TOP_HOLD,
        TOP_INSERT,
        TOP_JET,
        TOP_HOT
    } tbl_op_t;

    // control broadcast to the cell row
    typedef struct packed {
        tbl_op_t     op;
        entry_t      new_entry;
        logic [15:0] query;
    } cell_ctl_t;

    // sequencer states
    typedef enum logic [2:0] {
        FS_IDLE,
        FS_SCAN,
        FS_LOAD,
        FS_DIV,
        FS_MUL,
        FS_OUT
    } fsm_t;

    // jet preset entries
    function automatic entry_t jet_entry(input int idx);
        entry_t e;
        e = '0;
        case (idx)
            0: e = '{lvl: 16'd0,     red: 8'd0,   green: 8'd0,   blue: 8'd0};
            1: e = '{lvl: 16'd5439,  red: 8'd0,   green: 8'd0,   blue: 8'd255};
            2: e = '{lvl: 16'd10912, red: 8'd0,   green: 8'd255, blue: 8'd255};
            3: e = '{lvl: 16'd10912, red: 8'd0,   green: 8'd255, blue: 8'd255};
            4: e = '{lvl: 16'd16384, red: 8'd0,   green: 8'd255, blue: 8'd0};
            5: e = '{lvl: 16'd21823, red: 8'd255, green: 8'd255, blue: 8'd0};
            6: e = '{lvl: 16'd27296, red: 8'd255, green: 8'd0,   blue: 8'd0};
            7: e = '{lvl: 16'd32768, red: 8'd255, green: 8'd255, blue: 8'd255};
            default: e = '0;
        endcase
        return e;
    endfunction

    // hot preset entries
    function automatic entry_t hot_entry(input int idx);
        entry_t e;
        e = '0;
        case (idx)
            0: e = '{lvl: 16'd0,     red: 8'd0,   green: 8'd0,   blue: 8'd0};
            1: e = '{lvl: 16'd10912, red: 8'd255, green: 8'd0,   blue: 8'd0};
            2: e = '{lvl: 16'd21823, red: 8'd255, green: 8'd255, blue: 8'd0};
            3: e = '{lvl: 16'd32768, red: 8'd255, green: 8'd255, blue: 8'd255};
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

// ===== design/cmgi_cell.sv =====
// one breakpoint cell of the sorted table row
// depends on cmgi_pkg; cells chain left to right, insert shifts right,
// the lookup pair travels right through the carry registers
module cmgi_cell
    import cmgi_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic                                 clk,
    input  cell_ctl_t                            ctl,
    input  logic [$clog2(MAX_POINTS+1)-1:0]      count,
    input  entry_t                               left_entry,
    input  logic                                 left_gt,
    input  logic                                 left_take,
    input  pair_t                                carry_in,
    output entry_t                               entry,
    output logic                                 gt,
    output logic                                 take,
    output pair_t                                carry_out
);

    localparam int             CW       = $clog2(MAX_POINTS+1);
    localparam logic [CW-1:0]  IDX_C    = CW'(IDX);
    localparam logic [CW-1:0]  NEXT_C   = CW'(IDX + 1);
    localparam bit             HAS_LEFT = (IDX != 0);
    localparam bit             IN_JET   = (IDX < JET_N);
    localparam bit             IN_HOT   = (IDX < HOT_N);
    localparam entry_t         JET_E    = jet_entry(IDX);
    localparam entry_t         HOT_E    = hot_entry(IDX);

    entry_t entry_reg, entry_next;
    pair_t  carry_reg, carry_next;
    logic   valid, first, last, sel;
    pair_t  own_pair;

    // position flags; valid entries are sorted so gt is set on a suffix
    assign valid = (IDX_C < count);
    assign gt    = valid && (ctl.query < entry_reg.lvl);
    assign take  = gt || (count == IDX_C);
    assign first = gt && !left_gt;
    assign last  = (count == NEXT_C) && !gt;
    assign sel   = first || last;

    // pair this cell offers: neighbor and self, or self twice at the ends
    always_comb
    begin
        own_pair.cur = entry_reg;
        own_pair.prv = (first && HAS_LEFT) ? left_entry : entry_reg;
    end

    // table entry update
    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            TOP_INSERT:
            begin
                if (take)
                begin
                    entry_next = left_take ? left_entry : ctl.new_entry;
                end
            end
            TOP_JET:
            begin
                if (IN_JET)
                begin
                    entry_next = JET_E;
                end
            end
            TOP_HOT:
            begin
                if (IN_HOT)
                begin
                    entry_next = HOT_E;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // carry chain: load own pair when selected, else pass the neighbor's
    assign carry_next = sel ? own_pair : carry_in;

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        carry_reg <= carry_next;
    end

    assign entry     = entry_reg;
    assign carry_out = carry_reg;

endmodule

// ===== design/cmgi_div.sv =====
// restoring divider for the interpolation fraction, one quotient bit a cycle
// depends on cmgi_pkg; quot = (num << 16) / den for num <= den
module cmgi_div
    import cmgi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [15:0]           num,
    input  logic [15:0]           den,
    output logic                  done,
    output logic [DIV_STEPS-1:0]  quot
);

    logic [16:0]          rem_reg, rem_next;
    logic [15:0]          den_reg, den_next;
    logic [DIV_STEPS-1:0] quo_reg, quo_next;
    logic [DIV_CW-1:0]    cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [17:0]          diff;
    logic                 ge;
    logic [16:0]          rem_kept;

    // trial subtract
    assign diff     = {1'b0, rem_reg} - {2'b00, den_reg};
    assign ge       = !diff[17];
    assign rem_kept = ge ? diff[16:0] : rem_reg;

    // step control
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = {1'b0, num};
            den_next = den;
            quo_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = {rem_kept[15:0], 1'b0};
            quo_next = {quo_reg[DIV_STEPS-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== design/colormap_gradient_interpolator.sv =====
// top level of the piecewise-linear colormap lookup
// depends on cmgi_pkg, cmgi_cell and cmgi_div
//
//   channel   signals                                       direction  transfer
//   command   start, busy, kind, red_in, green_in,          in         start && !busy
//             blue_in, level
//   result    done, red_out, green_out, blue_out, status    out        done (one cycle)
//
// insert, clear, presets, a full insert and an empty lookup: result in the
// cycle after the transfer, busy stays low, a new command may follow at once.
// a lookup holds busy while the pair travels the cell row's carry chain, the
// sequencer loads the divider, the divider produces its 17 quotient bits and
// its done strobe, then one multiply and one add/clamp stage; the result shows
// in the cycle after that.
// reset clears the point count and the sequencer; table entries are not reset.
// the receiver cannot stall: each result is shown for exactly one cycle.
module colormap_gradient_interpolator
    import cmgi_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [7:0]  red_in,
    input  logic [7:0]  green_in,
    input  logic [7:0]  blue_in,
    input  logic [15:0] level,
    output logic        done,
    output logic [7:0]  red_out,
    output logic [7:0]  green_out,
    output logic [7:0]  blue_out,
    output logic [1:0]  status
);

    localparam int            CW     = $clog2(MAX_POINTS+1);
    localparam int            SW     = $clog2(MAX_POINTS);
    localparam logic [CW-1:0] FULL_C = CW'(MAX_POINTS);
    localparam logic [CW-1:0] JET_C  = CW'(JET_N);
    localparam logic [CW-1:0] HOT_C  = CW'(HOT_N);
    localparam logic [SW-1:0] SCAN_LAST = SW'(MAX_POINTS - 1);

    fsm_t          state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] scan_reg, scan_next;
    logic [15:0]   lv_reg;
    logic          done_reg, done_next;
    logic [1:0]    status_reg, status_next;
    logic [7:0]    red_reg, red_next;
    logic [7:0]    green_reg, green_next;
    logic [7:0]    blue_reg, blue_next;
    logic signed [26:0] prod_r_reg, prod_g_reg, prod_b_reg;

    logic          accept;
    logic          full;
    logic          div_start;
    logic          div_done;
    logic [DIV_STEPS-1:0] fract;
    cell_ctl_t     ctl;
    pair_t         pick;
    logic [15:0]   div_num, div_den;

    entry_t entry_ch [0:MAX_POINTS];
    logic   gt_ch    [0:MAX_POINTS];
    logic   take_ch  [0:MAX_POINTS];
    pair_t  carry_ch [0:MAX_POINTS];

    assign accept = start && !busy;
    assign full   = (count_reg == FULL_C);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (accept && (kind == K_LOOKUP) && (count_reg != '0))
                begin
                    state_next = FS_SCAN;
                end
            end
            FS_SCAN:
            begin
                if (scan_reg == SCAN_LAST)
                begin
                    state_next = FS_LOAD;
                end
            end
            FS_LOAD:
            begin
                state_next = FS_DIV;
            end
            FS_DIV:
            begin
                if (div_done)
                begin
                    state_next = FS_MUL;
                end
            end
            FS_MUL:
            begin
                state_next = FS_OUT;
            end
            FS_OUT:
            begin
                state_next = FS_IDLE;
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    // state-decoded outputs
    always_comb
    begin
        busy      = 1'b1;
        div_start = 1'b0;
        case (state_reg)
            FS_IDLE:
            begin
                busy = 1'b0;
            end
            FS_LOAD:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                busy      = 1'b1;
                div_start = 1'b0;
            end
        endcase
    end

    // table command broadcast to the cells
    always_comb
    begin
        ctl.op        = TOP_HOLD;
        ctl.new_entry = '{lvl: level, red: red_in, green: green_in, blue: blue_in};
        ctl.query     = busy ? lv_reg : level;
        if (accept)
        begin
            case (kind)
                K_INSERT:
                begin
                    if (!full)
                    begin
                        ctl.op = TOP_INSERT;
                    end
                end
                K_JET:
                begin
                    ctl.op = TOP_JET;
                end
                K_HOT:
                begin
                    ctl.op = TOP_HOT;
                end
                default:
                begin
                    ctl.op = TOP_HOLD;
                end
            endcase
        end
    end

    // point count
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            case (kind)
                K_INSERT:
                begin
                    if (!full)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                K_CLEAR:
                begin
                    count_next = '0;
                end
                K_JET:
                begin
                    count_next = JET_C;
                end
                K_HOT:
                begin
                    count_next = HOT_C;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // scan cycle counter
    always_comb
    begin
        scan_next = '0;
        if (state_reg == FS_SCAN)
        begin
            scan_next = scan_reg + 1'b1;
        end
    end

    // per-channel blend: cur + floor(p / 65536), clamped to 0..255
    function automatic logic [7:0] blend_out(input logic [7:0] cur,
                                             input logic signed [26:0] p);
        logic signed [11:0] v;
        logic [7:0]         r;
        v = $signed({4'b0000, cur}) + $signed({p[26], p[26:16]});
        if (v[11])
        begin
            r = 8'd0;
        end
        else if (v > 12'sd255)
        begin
            r = 8'd255;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

    // signed color difference times fraction
    function automatic logic signed [26:0] scale(input logic [7:0] prv,
                                                 input logic [7:0] cur,
                                                 input logic [DIV_STEPS-1:0] f);
        logic signed [8:0]  d;
        logic signed [26:0] dx;
        logic signed [26:0] fx;
        d  = $signed({1'b0, prv}) - $signed({1'b0, cur});
        dx = {{18{d[8]}}, d};
        fx = $signed({10'b0, f});
        return dx * fx;
    endfunction

    // result registers
    always_comb
    begin
        done_next   = 1'b0;
        status_next = status_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        blue_next   = blue_reg;
        if (accept)
        begin
            red_next   = 8'd0;
            green_next = 8'd0;
            blue_next  = 8'd0;
            case (kind)
                K_INSERT:
                begin
                    done_next   = 1'b1;
                    status_next = full ? STS_FULL : STS_DONE;
                end
                K_LOOKUP:
                begin
                    if (count_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = STS_EMPTY;
                    end
                end
                default:
                begin
                    done_next   = 1'b1;
                    status_next = STS_DONE;
                end
            endcase
        end
        else if (state_reg == FS_OUT)
        begin
            done_next   = 1'b1;
            status_next = STS_COLOR;
            red_next    = blend_out(pick.cur.red, prod_r_reg);
            green_next  = blend_out(pick.cur.green, prod_g_reg);
            blue_next   = blend_out(pick.cur.blue, prod_b_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FS_IDLE;
            count_reg  <= '0;
            scan_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= STS_DONE;
            red_reg    <= 8'd0;
            green_reg  <= 8'd0;
            blue_reg   <= 8'd0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            scan_reg   <= scan_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
        end
    end

    // query level and products
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lv_reg <= level;
        end
        if (state_reg == FS_MUL)
        begin
            prod_r_reg <= scale(pick.prv.red, pick.cur.red, fract);
            prod_g_reg <= scale(pick.prv.green, pick.cur.green, fract);
            prod_b_reg <= scale(pick.prv.blue, pick.cur.blue, fract);
        end
    end

    // chain heads
    assign entry_ch[0] = '0;
    assign gt_ch[0]    = 1'b0;
    assign take_ch[0]  = 1'b0;
    assign carry_ch[0] = '0;

    // row of breakpoint cells
    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        cmgi_cell #(
            .IDX        (i),
            .MAX_POINTS (MAX_POINTS)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count_reg),
            .left_entry (entry_ch[i]),
            .left_gt    (gt_ch[i]),
            .left_take  (take_ch[i]),
            .carry_in   (carry_ch[i]),
            .entry      (entry_ch[i+1]),
            .gt         (gt_ch[i+1]),
            .take       (take_ch[i+1]),
            .carry_out  (carry_ch[i+1])
        );
    end

    assign pick    = carry_ch[MAX_POINTS];
    assign div_num = pick.cur.lvl - lv_reg;
    assign div_den = pick.cur.lvl - pick.prv.lvl;

    // fraction divider
    cmgi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (fract)
    );

    assign done      = done_reg;
    assign status    = status_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

endmodule

// ===== dv/tb_colormap_gradient_interpolator.sv =====
// self-checking testbench for colormap_gradient_interpolator
// holds its own breakpoint table and interpolation predictor, drives commands, checks results
// depends on cmgi_pkg and the colormap_gradient_interpolator rtl
module tb_colormap_gradient_interpolator
    import cmgi_pkg::*;
();

    localparam int NPTS          = MAX_POINTS_DEF;
    localparam int N_DIRECTED    = 27;
    localparam int N_PHASES      = 4;
    localparam int ITEMS_PER_PH  = 100;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = NPTS + 30;
    localparam int MAX_SHOWN     = 10;
    // expected-result ring, deeper than every command of the run
    localparam int RING_DEPTH    = 512;

    // kind codes the block ignores
    localparam logic [2:0] K_RSVD_LO  = 3'd5;
    localparam logic [2:0] K_RSVD_MID = 3'd6;
    localparam logic [2:0] K_RSVD_HI  = 3'd7;

    // one result as seen on the output ports
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] status;
    } color_res_t;

    // one row of the directed stimulus
    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] lvl;
        bit          typed;
        color_res_t  want;
    } cmd_row_t;

    localparam color_res_t WANT_DONE  = '{8'd0, 8'd0, 8'd0, STS_DONE};
    localparam color_res_t WANT_EMPTY = '{8'd0, 8'd0, 8'd0, STS_EMPTY};
    localparam color_res_t WANT_FULL  = '{8'd0, 8'd0, 8'd0, STS_FULL};
    localparam color_res_t WANT_WHITE = '{8'd255, 8'd255, 8'd255, STS_COLOR};
    localparam color_res_t WANT_CALC  = '0;

    // preset tables: levels are close to the fractions 0, 1/6 .. 1 scaled by 32768
    localparam entry_t JET_PTS [JET_N] = '{
        '{16'd0,     8'd0,   8'd0,   8'd0},
        '{16'd5439,  8'd0,   8'd0,   8'd255},
        '{16'd10912, 8'd0,   8'd255, 8'd255},
        '{16'd10912, 8'd0,   8'd255, 8'd255},
        '{16'd16384, 8'd0,   8'd255, 8'd0},
        '{16'd21823, 8'd255, 8'd255, 8'd0},
        '{16'd27296, 8'd255, 8'd0,   8'd0},
        '{16'd32768, 8'd255, 8'd255, 8'd255}
    };
    localparam entry_t HOT_PTS [HOT_N] = '{
        '{16'd0,     8'd0,   8'd0,   8'd0},
        '{16'd10912, 8'd255, 8'd0,   8'd0},
        '{16'd21823, 8'd255, 8'd255, 8'd0},
        '{16'd32768, 8'd255, 8'd255, 8'd255}
    };

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  kind;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [15:0] level;
    logic        done;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [1:0]  status;

    // predictor copy of the breakpoint table
    entry_t      map_pts [NPTS];
    int          map_count;

    // expected results in transfer order
    color_res_t  exp_ring [RING_DEPTH];
    int          ring_wr;
    int          ring_rd;
    cmd_row_t    dir_rows [N_DIRECTED];
    int          gap_pct;
    int          n_errors;
    int          n_sent;
    int          n_results;
    int          n_lookups;
    int          n_full;
    int          n_empty;
    int          idle_cycles;

    colormap_gradient_interpolator #(
        .MAX_POINTS (NPTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .level     (level),
        .done      (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .status    (status)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // cur + floor((prv - cur) * fract / 65536), clamped to a byte
    function automatic logic [7:0] blend_chan(input logic [7:0] prv, input logic [7:0] cur,
                                              input logic [16:0] fract);
        longint diff;
        longint v;
        diff = longint'(prv) - longint'(cur);
        v = longint'(cur) + ((diff * longint'(fract)) >>> 16);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // apply one command to the predictor table and return the result it causes
    function automatic color_res_t run_command(input logic [2:0] cmd, input logic [7:0] r,
                                               input logic [7:0] g, input logic [7:0] b,
                                               input logic [15:0] lvl);
        color_res_t  res;
        int          pos;
        entry_t      cur;
        entry_t      prv;
        logic [31:0] num;
        logic [16:0] fract;
        res = WANT_DONE;
        case (cmd)
            K_INSERT:
            begin
                if (map_count >= NPTS)
                begin
                    res.status = STS_FULL;
                end
                else
                begin
                    // new point goes after every point of equal level
                    pos = map_count;
                    for (int i = 0; i < map_count; i++)
                    begin
                        if (lvl < map_pts[i].lvl)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = map_count; i > pos; i--) map_pts[i] = map_pts[i-1];
                    map_pts[pos] = '{lvl, r, g, b};
                    map_count++;
                end
            end
            K_CLEAR: map_count = 0;
            K_JET:
            begin
                for (int i = 0; i < JET_N; i++) map_pts[i] = JET_PTS[i];
                map_count = JET_N;
            end
            K_HOT:
            begin
                for (int i = 0; i < HOT_N; i++) map_pts[i] = HOT_PTS[i];
                map_count = HOT_N;
            end
            K_LOOKUP:
            begin
                if (map_count == 0)
                begin
                    res.status = STS_EMPTY;
                end
                else
                begin
                    pos = map_count;
                    for (int i = 0; i < map_count; i++)
                    begin
                        if (lvl < map_pts[i].lvl)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos == map_count || pos == 0)
                    begin
                        // clamp to the last or the first color
                        cur = (pos == 0) ? map_pts[0] : map_pts[map_count-1];
                        res = '{cur.red, cur.green, cur.blue, STS_COLOR};
                    end
                    else
                    begin
                        cur = map_pts[pos];
                        prv = map_pts[pos-1];
                        fract = '0;
                        if (cur.lvl > prv.lvl)
                        begin
                            num = {16'(cur.lvl - lvl), 16'd0};
                            fract = 17'(num / 32'(cur.lvl - prv.lvl));
                        end
                        res.red    = blend_chan(prv.red, cur.red, fract);
                        res.green  = blend_chan(prv.green, cur.green, fract);
                        res.blue   = blend_chan(prv.blue, cur.blue, fract);
                        res.status = STS_COLOR;
                    end
                end
            end
            default: res = WANT_DONE;
        endcase
        return res;
    endfunction

    // present one command, wait for its transfer, record what it should produce
    task automatic issue_cmd(input logic [2:0] k, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [15:0] lvl, input bit typed,
                             input color_res_t want);
        color_res_t pred;
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        kind     <= k;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        level    <= lvl;
        do @(posedge clk); while (busy);
        pred = run_command(k, r, g, b, lvl);
        if (typed) pred = want;
        exp_ring[ring_wr % RING_DEPTH] = pred;
        ring_wr++;
        n_sent++;
        if (pred.status == STS_COLOR) n_lookups++;
        if (pred.status == STS_FULL) n_full++;
        if (pred.status == STS_EMPTY) n_empty++;
    endtask

    // level picker biased toward breakpoints and the ends of the range
    function automatic logic [15:0] pick_level();
        int roll;
        logic [15:0] base;
        roll = $urandom_range(99);
        base = (map_count > 0) ? map_pts[$urandom_range(map_count - 1)].lvl : 16'd16384;
        if (roll < 25) return 16'($urandom_range(65535));
        if (roll < 55) return 16'($urandom_range(32768));
        if (roll < 75) return base + 16'($urandom_range(6)) - 16'd3;
        if (roll < 85) return base;
        if (roll < 92) return 16'd0;
        return 16'hffff;
    endfunction

    function automatic logic [7:0] pick_chan();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) return 8'd0;
        if (roll == 1) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    // mostly table building and lookups, with occasional resets of the table and reserved kind codes
    task automatic random_cmd();
        int roll;
        logic [2:0] k;
        roll = $urandom_range(99);
        if (roll < 40)      k = K_INSERT;
        else if (roll < 82) k = K_LOOKUP;
        else if (roll < 88) k = K_CLEAR;
        else if (roll < 92) k = K_JET;
        else if (roll < 96) k = K_HOT;
        else                k = K_RSVD_LO + 3'($urandom_range(2));
        issue_cmd(k, pick_chan(), pick_chan(), pick_chan(), pick_level(), 1'b0, WANT_CALC);
    endtask

    // hold off until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        while (ring_wr != ring_rd) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input color_res_t want,
                                   input color_res_t got);
        n_errors++;
        if (n_errors <= MAX_SHOWN)
            $display("%s: expected rgb %0d/%0d/%0d status %0d, got rgb %0d/%0d/%0d status %0d",
                     what, want.red, want.green, want.blue, want.status,
                     got.red, got.green, got.blue, got.status);
    endtask

    // result checker: one transfer per done strobe
    always @(posedge clk)
    begin
        color_res_t got;
        color_res_t want;
        if (rst_n && done)
        begin
            got = '{red_out, green_out, blue_out, status};
            n_results++;
            if (ring_wr == ring_rd)
            begin
                report_mismatch("unexpected result", WANT_CALC, got);
            end
            else
            begin
                want = exp_ring[ring_rd % RING_DEPTH];
                ring_rd++;
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.status !== want.status)
                    report_mismatch($sformatf("result %0d", n_results), want, got);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transfer in %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus and end of run
    initial
    begin
        int phase_gap [N_PHASES];
        start       <= 1'b0;
        kind        <= K_CLEAR;
        red_in      <= 8'd0;
        green_in    <= 8'd0;
        blue_in     <= 8'd0;
        level       <= 16'd0;
        rst_n       <= 1'b0;
        idle_cycles <= 0;
        map_count   = 0;
        ring_wr     = 0;
        ring_rd     = 0;
        n_errors    = 0;
        n_sent      = 0;
        n_results   = 0;
        n_lookups   = 0;
        n_full      = 0;
        n_empty     = 0;
        gap_pct     = 0;
        // receiver cannot stall, so its idling phases reduce to sender pacing
        phase_gap   = '{0, 80, 0, 9};

        dir_rows = '{
            '{K_LOOKUP,   8'd0,   8'd0,   8'd0,   16'd0,     1'b1, WANT_EMPTY},
            '{K_INSERT,   8'd255, 8'd255, 8'd255, 16'hffff,  1'b1, WANT_DONE},
            '{K_LOOKUP,   8'd0,   8'd0,   8'd0,   16'd100,   1'b1, WANT_WHITE},
            '{K_LOOKUP,   8'd0,   8'd0,   8'd0,   16'hffff,  1'b1, WANT_WHITE},
            '{K_INSERT,   8'd0,   8'd0,   8'd0,   16'd0,     1'b1, WANT_DONE},
            '{K_LOOKUP,   8'd0,   8'd0,   8'd0,   16'd32768, 1'b0, WANT_CALC},
            '{K_RSVD_LO,  8'd255, 8'd255, 8'd255, 16'hffff,  1'b1, WANT_DONE},
            '{K_RSVD_MID, 8'd255, 8'd0,   8'd255, 16'h5555,  1'b1, WANT_DONE},
            '{K_RSVD_HI,  8'd0,   8'd255, 8'd0,   16'haaaa,  1'b1, WANT_DONE},
            '{K_CLEAR,    8'd0,   8'd0,   8'd0,   16'd0,     1'b1, WANT_DONE},
            '{K_LOOKUP,   8'd0,   8'd0,   8'd0,   16'd500,   1'b1, WANT_EMPTY},
            '{K_HOT,      8'd0,   8'd0,   8'd0,   16'd0,     1'b1, WANT_DONE},
            '{K_LOOKUP,   8'd0,   8'd0,   8'd0,   16'd20000, 1'b0, WANT_CALC},
            '{K_LOOKUP,   8'd0,   8'd0,   8'd0,   16'd32768, 1'b1, WANT_WHITE},
            '{K_JET,      8'd0,   8'd0,   8'd0,   16'd0,     1'b1, WANT_DONE},
            '{K_LOOKUP,   8'd0,   8'd0,   8'd0,   16'd10912, 1'b0, WANT_CALC},
            '{K_LOOKUP,   8'd0,   8'd0,   8'd0,   16'd16000, 1'b0, WANT_CALC},
            '{K_INSERT,   8'd17,  8'd200, 8'd99,  16'd10912, 1'b1, WANT_DONE},
            '{K_INSERT,   8'd255, 8'd0,   8'd128, 16'd0,     1'b1, WANT_DONE},
            '{K_INSERT,   8'd1,   8'd2,   8'd3,   16'hffff,  1'b1, WANT_DONE},
            '{K_INSERT,   8'd90,  8'd180, 8'd45,  16'd40000, 1'b1, WANT_DONE},
            '{K_INSERT,   8'd128, 8'd64,  8'd32,  16'd1,     1'b1, WANT_DONE},
            '{K_INSERT,   8'd0,   8'd0,   8'd0,   16'd32768, 1'b1, WANT_DONE},
            '{K_INSERT,   8'd77,  8'd7,   8'd177, 16'd20000, 1'b1, WANT_DONE},
            '{K_INSERT,   8'd240, 8'd15,  8'd60,  16'd5439,  1'b1, WANT_DONE},
            '{K_INSERT,   8'd255, 8'd255, 8'd255, 16'd12345, 1'b1, WANT_FULL},
            '{K_LOOKUP,   8'd0,   8'd0,   8'd0,   16'd36000, 1'b0, WANT_CALC}
        };

        // reset once at the start
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows back to back
        foreach (dir_rows[i])
            issue_cmd(dir_rows[i].kind, dir_rows[i].red, dir_rows[i].green,
                      dir_rows[i].blue, dir_rows[i].lvl, dir_rows[i].typed, dir_rows[i].want);
        drain();

        // random phases, each ending with a full drain
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            gap_pct = phase_gap[ph];
            repeat (ITEMS_PER_PH) random_cmd();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d commands issued, %0d results checked", n_sent, n_results);
        $display("%0d color lookups, %0d full-table inserts, %0d empty-table lookups",
                 n_lookups, n_full, n_empty);
        if (n_errors == 0 && ring_wr == ring_rd)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", n_errors, ring_wr - ring_rd);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
